@@ src/ajb_pkg.sv @@
package ajb_pkg;

  // Default sizing
  localparam int MAX_FRAMES_DEF   = 32;
  localparam int PAYLOAD_BITS_DEF = 64;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int SEQ_W   = 31;
  localparam int WORD_W  = 64;
  localparam int PF_W    = 6;
  localparam int LIMIT_W = 10;
  localparam int IDX_W   = 2;
  localparam int STAB_W  = 11;

  // Arithmetic limits
  localparam logic signed [15:0] LEVEL_LIM = 16'sd32767;
  localparam logic [15:0]        COUNT_MAX = 16'hFFFF;

  // Divide by three through a reciprocal, exact for values below 128
  localparam int RECIP3    = 43;
  localparam int RECIP3_SH = 7;

  // Register reset values
  localparam logic [PF_W-1:0]    INIT_PF_RST = 6'd15;
  localparam logic [PF_W-1:0]    MIN_PF_RST  = 6'd0;
  localparam logic [PF_W-1:0]    MAX_PF_RST  = 6'd25;
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 10'd50;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FT_NORMAL        = 2'd0,
    FT_MISSING       = 2'd1,
    FT_ZERO_PREFETCH = 2'd2,
    FT_ZERO_EMPTY    = 2'd3
  } ftype_t;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PUT  = 2'd1,
    OP_GET  = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_INIT_PF = 2'd0,
    REG_MIN_PF  = 2'd1,
    REG_MAX_PF  = 2'd2,
    REG_LIMIT   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUT_A,
    S_PUT_B,
    S_GET_A,
    S_ADAPT_A,
    S_ADAPT_B,
    S_SHRINK,
    S_PLACE,
    S_APPLY,
    S_GET_B,
    S_GET_C,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] payload_in;
  } in_t;

  typedef struct packed {
    logic [1:0]        frame_type;
    logic [WORD_W-1:0] payload_out;
    logic              stored;
    logic [PF_W-1:0]   cur_prefetch;
    logic [PF_W-1:0]   fill;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic put_a;
    logic put_b;
    logic get_a;
    logic adapt_a;
    logic adapt_b;
    logic shrink;
    logic place_chk;
    logic wr;
    logic drop;
    logic get_b;
    logic get_c;
    logic clr;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             started;
    logic [1:0]       last_op;
    logic             diff_pos;
    logic             shrink_go;
    logic             chk_ok;
    logic             pop_go;
  } dp_stat_t;

endpackage

@@ src/ajb_ctrl.sv @@
module ajb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ajb_pkg::dp_stat_t stat,
  output ajb_pkg::dp_cmd_t  cmd
);

  ajb_pkg::state_t state, state_next;
  logic            adapt_needed;
  logic            is_put;

  assign is_put = (stat.item_cmd == ajb_pkg::CMD_PUT);

  // Kind change between put and get triggers adaptation; so does a get, or a put once started, before any adaptation
  always_comb begin
    if (is_put) begin
      adapt_needed = stat.started && (stat.last_op != ajb_pkg::OP_PUT);
    end else begin
      adapt_needed = (stat.last_op != ajb_pkg::OP_GET);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ajb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ajb_pkg::S_IDLE: begin
        if (in_valid) state_next = ajb_pkg::S_DECODE;
      end
      ajb_pkg::S_DECODE: begin
        case (stat.item_cmd)
          ajb_pkg::CMD_PUT:   state_next = ajb_pkg::S_PUT_A;
          ajb_pkg::CMD_GET:   state_next = ajb_pkg::S_GET_A;
          ajb_pkg::CMD_RESET: state_next = ajb_pkg::S_CLR;
          default:            state_next = ajb_pkg::S_DONE;
        endcase
      end
      ajb_pkg::S_PUT_A: state_next = ajb_pkg::S_PUT_B;
      ajb_pkg::S_PUT_B: begin
        state_next = adapt_needed ? ajb_pkg::S_ADAPT_A : ajb_pkg::S_PLACE;
      end
      ajb_pkg::S_GET_A: begin
        state_next = adapt_needed ? ajb_pkg::S_ADAPT_A : ajb_pkg::S_GET_B;
      end
      ajb_pkg::S_ADAPT_A: state_next = ajb_pkg::S_ADAPT_B;
      ajb_pkg::S_ADAPT_B: begin
        if (stat.shrink_go) begin
          state_next = ajb_pkg::S_SHRINK;
        end else begin
          state_next = is_put ? ajb_pkg::S_PLACE : ajb_pkg::S_GET_B;
        end
      end
      ajb_pkg::S_SHRINK: begin
        state_next = is_put ? ajb_pkg::S_PLACE : ajb_pkg::S_GET_B;
      end
      ajb_pkg::S_PLACE: state_next = ajb_pkg::S_APPLY;
      ajb_pkg::S_APPLY: begin
        if (!stat.chk_ok && stat.diff_pos) begin
          state_next = ajb_pkg::S_PLACE;
        end else begin
          state_next = ajb_pkg::S_DONE;
        end
      end
      ajb_pkg::S_GET_B: begin
        state_next = stat.pop_go ? ajb_pkg::S_GET_C : ajb_pkg::S_DONE;
      end
      ajb_pkg::S_GET_C: state_next = ajb_pkg::S_DONE;
      ajb_pkg::S_CLR:   state_next = ajb_pkg::S_DONE;
      ajb_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = ajb_pkg::S_IDLE;
      end
      default: state_next = ajb_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ajb_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ajb_pkg::S_PUT_A:   cmd.put_a     = 1'b1;
      ajb_pkg::S_PUT_B:   cmd.put_b     = 1'b1;
      ajb_pkg::S_GET_A:   cmd.get_a     = 1'b1;
      ajb_pkg::S_ADAPT_A: cmd.adapt_a   = 1'b1;
      ajb_pkg::S_ADAPT_B: cmd.adapt_b   = 1'b1;
      ajb_pkg::S_SHRINK:  cmd.shrink    = 1'b1;
      ajb_pkg::S_PLACE:   cmd.place_chk = 1'b1;
      ajb_pkg::S_APPLY: begin
        cmd.wr   = stat.chk_ok;
        cmd.drop = !stat.chk_ok && stat.diff_pos;
      end
      ajb_pkg::S_GET_B: cmd.get_b = 1'b1;
      ajb_pkg::S_GET_C: cmd.get_c = 1'b1;
      ajb_pkg::S_CLR:   cmd.clr   = 1'b1;
      ajb_pkg::S_DONE:  cmd.out_load = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  // Output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/ajb_datapath.sv @@
module ajb_datapath #(
  parameter int MAX_FRAMES   = ajb_pkg::MAX_FRAMES_DEF,
  parameter int PAYLOAD_BITS = ajb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ajb_pkg::in_t                in_data,
  output ajb_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [ajb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ajb_pkg::LIMIT_W-1:0] cfg_data,
  input  ajb_pkg::dp_cmd_t            cmd,
  output ajb_pkg::dp_stat_t           stat
);

  localparam int AW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SW      = $clog2(MAX_FRAMES + 1);
  localparam int QUARTER = (MAX_FRAMES / 4 < 1) ? 1 : MAX_FRAMES / 4;
  localparam int CAP     = (MAX_FRAMES * 4) / 5;
  localparam int PW      = ajb_pkg::PF_W;

  // Add modulo ring depth; operand is below twice the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW:0] a);
    logic [AW:0] s;
    s = (a >= (AW+1)'(MAX_FRAMES)) ? a - (AW+1)'(MAX_FRAMES) : a;
    return s[AW-1:0];
  endfunction

  // Configuration
  logic [PW-1:0]                  cfg_min, cfg_max;
  logic [ajb_pkg::LIMIT_W-1:0]    cfg_limit;

  // Item and result holding
  logic [1:0]                     it_cmd;
  logic [ajb_pkg::SEQ_W-1:0]      it_seq;
  logic [PAYLOAD_BITS-1:0]        it_data;
  logic [1:0]                     r_ftype;
  logic [ajb_pkg::WORD_W-1:0]     r_pay;
  logic                           r_stored;

  // Adaptation state
  logic [PW-1:0]                  prefetch_now;
  logic                           seq_known;
  logic signed [31:0]             last_seq;
  logic signed [32:0]             diff;
  logic signed [15:0]             level, prev_level;
  logic [15:0]                    hist_max_jitter, jit;
  logic [ajb_pkg::STAB_W-1:0]     stable_count;
  logic [1:0]                     last_op;
  logic [15:0]                    prefetch_count;
  logic                           started;

  // Ring state
  logic [AW-1:0]                  head_ptr, tail_ptr;
  logic                           ring_empty;
  logic [31:0]                    origin_seq;
  logic [MAX_FRAMES-1:0]          slot_present;
  logic [PAYLOAD_BITS-1:0]        slot_payload [MAX_FRAMES];
  logic [PAYLOAD_BITS-1:0]        rdata;
  logic                           chk_ok, set_origin, pres_r;
  logic [AW-1:0]                  where_r, tail_new;

  // Combinational terms
  logic [SW-1:0]                  ring_size;
  logic [31:0]                    seq32;
  logic signed [31:0]             ls_eff;
  logic signed [32:0]             diff_c;
  logic signed [33:0]             lvl_sum;
  logic signed [15:0]             lvl_sat, lvl_dec;
  logic signed [16:0]             d17;
  logic [15:0]                    jit_c;
  logic                           jit_lt;
  logic [ajb_pkg::STAB_W-1:0]     sc_sum;
  logic [15:0]                    grow1, grow2;
  logic signed [17:0]             shr_t;
  logic [11:0]                    shr_prod;
  logic [4:0]                     shr_step;
  logic signed [7:0]              pf_sub;
  logic [PW-1:0]                  pf_shr;
  logic [31:0]                    top_seq, off_seq, end_seq, gap_seq;
  logic                           chk_ok_c, set_origin_c;
  logic [AW-1:0]                  where_c, tail_new_c;
  logic [SW-1:0]                  drop_cnt;
  logic [AW-1:0]                  head_drop, head_inc;
  logic [MAX_FRAMES-1:0]          drop_mask;
  logic [32:0]                    pc_sum;
  logic                           sz_zero, pc_lt, pop_go;
  logic [15:0]                    pc_eff;
  logic [1:0]                     get_ftype;

  assign seq32 = {1'b0, it_seq};

  // Occupancy of the ring
  always_comb begin
    if (head_ptr == tail_ptr) begin
      ring_size = ring_empty ? '0 : SW'(MAX_FRAMES);
    end else begin
      ring_size = SW'(wrap_add({1'b0, tail_ptr} + (AW+1)'(MAX_FRAMES) - {1'b0, head_ptr}));
    end
  end

  // Sequence tracking and level
  always_comb begin
    ls_eff  = seq_known ? last_seq : $signed(seq32 - 32'd1);
    diff_c  = $signed({2'b00, it_seq}) - $signed({ls_eff[31], ls_eff});
    lvl_sum = $signed({{18{level[15]}}, level}) + $signed({diff[32], diff});
    lvl_sat = (lvl_sum > 34'sd32767) ? ajb_pkg::LEVEL_LIM : lvl_sum[15:0];
    lvl_dec = (level > -ajb_pkg::LEVEL_LIM) ? level - 16'sd1 : level;
  end

  // Jitter and prefetch adaptation
  always_comb begin
    d17      = $signed({level[15], level}) - $signed({prev_level[15], prev_level});
    jit_c    = d17[16] ? 16'(-d17) : d17[15:0];
    jit_lt   = jit < {10'b0, prefetch_now};
    sc_sum   = stable_count + {5'b0, jit[5:0]};
    grow1    = (jit < 16'(CAP)) ? jit : 16'(CAP);
    grow2    = (grow1 > {10'b0, cfg_max}) ? {10'b0, cfg_max} : grow1;
    shr_t    = $signed({12'b0, prefetch_now}) - $signed({2'b0, hist_max_jitter});
    shr_prod = {6'b0, shr_t[5:0]} * 12'(ajb_pkg::RECIP3);
    shr_step = (shr_t < 18'sd3) ? 5'd1 : shr_prod[11:ajb_pkg::RECIP3_SH];
    pf_sub   = $signed({2'b0, prefetch_now}) - $signed({3'b0, shr_step});
    pf_shr   = (pf_sub < $signed({2'b0, cfg_min})) ? cfg_min : pf_sub[PW-1:0];
  end

  // Placement check for a put
  always_comb begin
    top_seq = origin_seq + 32'(MAX_FRAMES - 1);
    off_seq = seq32 - origin_seq;
    end_seq = origin_seq + 32'(ring_size);
    gap_seq = seq32 - end_seq;
    if (ring_empty) begin
      chk_ok_c     = 1'b1;
      set_origin_c = 1'b1;
      where_c      = tail_ptr;
      tail_new_c   = wrap_add({1'b0, tail_ptr} + (AW+1)'(1));
    end else begin
      chk_ok_c     = !((seq32 < origin_seq) || (seq32 > top_seq));
      set_origin_c = 1'b0;
      where_c      = wrap_add({1'b0, off_seq[AW-1:0]} + {1'b0, head_ptr});
      if (seq32 >= end_seq) begin
        tail_new_c = wrap_add({1'b0, tail_ptr} + (AW+1)'(gap_seq[AW-1:0]) + (AW+1)'(1));
      end else begin
        tail_new_c = tail_ptr;
      end
    end
  end

  // Eviction of a quarter ring, or of the whole ring if smaller, from the head
  always_comb begin
    logic [AW-1:0] off_i;
    drop_cnt  = (ring_size < SW'(QUARTER)) ? ring_size : SW'(QUARTER);
    head_drop = wrap_add({1'b0, head_ptr} + (AW+1)'(drop_cnt));
    head_inc  = wrap_add({1'b0, head_ptr} + (AW+1)'(1));
    for (int i = 0; i < MAX_FRAMES; i++) begin
      off_i        = wrap_add((AW+1)'(i) + (AW+1)'(MAX_FRAMES) - {1'b0, head_ptr});
      drop_mask[i] = SW'(off_i) < drop_cnt;
    end
  end

  // Get decision and prefetch count
  always_comb begin
    pc_sum  = {17'b0, prefetch_count} + $unsigned(diff);
    sz_zero = (ring_size == '0);
    pc_eff  = sz_zero ? 16'd0 : prefetch_count;
    pc_lt   = pc_eff < {10'b0, prefetch_now};
    pop_go  = !pc_lt && !ring_empty;
    if (pc_lt) begin
      get_ftype = sz_zero ? ajb_pkg::FT_ZERO_EMPTY : ajb_pkg::FT_ZERO_PREFETCH;
    end else if (ring_empty) begin
      get_ftype = ajb_pkg::FT_ZERO_EMPTY;
    end else begin
      get_ftype = slot_present[head_ptr] ? ajb_pkg::FT_NORMAL : ajb_pkg::FT_MISSING;
    end
  end

  // Status to controller
  always_comb begin
    stat.item_cmd  = it_cmd;
    stat.started   = started;
    stat.last_op   = last_op;
    stat.diff_pos  = diff > 33'sd0;
    stat.shrink_go = jit_lt && (sc_sum > {1'b0, cfg_limit});
    stat.chk_ok    = chk_ok;
    stat.pop_go    = pop_go;
  end

  // Configuration, history and adaptation registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_min         <= ajb_pkg::MIN_PF_RST;
      cfg_max         <= ajb_pkg::MAX_PF_RST;
      cfg_limit       <= ajb_pkg::LIMIT_RST;
      prefetch_now    <= ajb_pkg::INIT_PF_RST;
      seq_known       <= 1'b0;
      last_seq        <= '0;
      diff            <= '0;
      level           <= '0;
      prev_level      <= '0;
      hist_max_jitter <= '0;
      jit             <= '0;
      stable_count    <= '0;
      last_op         <= ajb_pkg::OP_INIT;
      prefetch_count  <= '0;
      started         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ajb_pkg::REG_INIT_PF: prefetch_now <= cfg_data[PW-1:0];
          ajb_pkg::REG_MIN_PF:  cfg_min      <= cfg_data[PW-1:0];
          ajb_pkg::REG_MAX_PF:  cfg_max      <= cfg_data[PW-1:0];
          ajb_pkg::REG_LIMIT:   cfg_limit    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.put_a) begin
        seq_known <= 1'b1;
        diff      <= diff_c;
        last_seq  <= (diff_c > 33'sd0) ? $signed(seq32) : ls_eff;
      end
      if (cmd.put_b) begin
        if (!started) begin
          started    <= 1'b1;
          level      <= '0;
          prev_level <= '0;
        end else if (diff > 33'sd0) begin
          level <= lvl_sat;
        end
      end
      if (cmd.get_a) begin
        level <= lvl_dec;
      end
      if (cmd.adapt_a) begin
        jit        <= jit_c;
        prev_level <= level;
        if (jit_c > hist_max_jitter) hist_max_jitter <= jit_c;
        last_op <= (it_cmd == ajb_pkg::CMD_PUT) ? ajb_pkg::OP_PUT : ajb_pkg::OP_GET;
      end
      if (cmd.adapt_b) begin
        if (!jit_lt) begin
          prefetch_now    <= grow2[PW-1:0];
          stable_count    <= '0;
          hist_max_jitter <= '0;
        end else if (!stat.shrink_go) begin
          stable_count <= sc_sum;
        end
      end
      if (cmd.shrink) begin
        prefetch_now    <= pf_shr;
        stable_count    <= '0;
        hist_max_jitter <= '0;
      end
      if (cmd.wr && (diff > 33'sd0) && (prefetch_count < {10'b0, prefetch_now})) begin
        prefetch_count <= (pc_sum > 33'd65535) ? ajb_pkg::COUNT_MAX : pc_sum[15:0];
      end
      if (cmd.get_b) begin
        prefetch_count <= pc_eff;
      end
      if (cmd.clr) begin
        seq_known       <= 1'b0;
        last_seq        <= '0;
        level           <= '0;
        prev_level      <= '0;
        hist_max_jitter <= '0;
        stable_count    <= '0;
        last_op         <= ajb_pkg::OP_INIT;
        prefetch_count  <= '0;
        started         <= 1'b0;
      end
    end
  end

  // Ring pointers and present bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr     <= '0;
      tail_ptr     <= '0;
      ring_empty   <= 1'b1;
      origin_seq   <= '0;
      slot_present <= '0;
      chk_ok       <= 1'b0;
    end else begin
      if (cmd.place_chk) begin
        chk_ok <= chk_ok_c;
      end
      if (cmd.wr) begin
        slot_present[where_r] <= 1'b1;
        tail_ptr <= tail_new;
        if (set_origin) begin
          origin_seq <= seq32;
          ring_empty <= 1'b0;
        end
      end
      if (cmd.drop) begin
        slot_present <= slot_present & ~drop_mask;
        origin_seq   <= origin_seq + 32'(drop_cnt);
        head_ptr     <= head_drop;
        if (head_drop == tail_ptr) ring_empty <= 1'b1;
      end
      if (cmd.get_b && pop_go) begin
        slot_present[head_ptr] <= 1'b0;
        origin_seq <= origin_seq + 32'd1;
        head_ptr   <= head_inc;
        if (head_inc == tail_ptr) ring_empty <= 1'b1;
      end
      if (cmd.clr && !sz_zero) begin
        slot_present <= '0;
        origin_seq   <= origin_seq + 32'(ring_size);
        head_ptr     <= tail_ptr;
        ring_empty   <= 1'b1;
      end
    end
  end

  // Payload store, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.wr) slot_payload[where_r] <= it_data;
    rdata <= slot_payload[head_ptr];
  end

  // Item capture, placement results and output beat
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd   <= in_data.cmd;
      it_seq   <= in_data.seq;
      it_data  <= in_data.payload_in[PAYLOAD_BITS-1:0];
      r_ftype  <= ajb_pkg::FT_NORMAL;
      r_pay    <= '0;
      r_stored <= 1'b0;
    end
    if (cmd.place_chk) begin
      where_r    <= where_c;
      tail_new   <= tail_new_c;
      set_origin <= set_origin_c;
    end
    if (cmd.wr) r_stored <= 1'b1;
    if (cmd.get_b) begin
      r_ftype <= get_ftype;
      pres_r  <= slot_present[head_ptr];
    end
    if (cmd.get_c) begin
      r_pay <= pres_r ? ajb_pkg::WORD_W'(rdata) : '0;
    end
    if (cmd.out_load) begin
      out_data.frame_type   <= r_ftype;
      out_data.payload_out  <= r_pay;
      out_data.stored       <= r_stored;
      out_data.cur_prefetch <= prefetch_now;
      out_data.fill         <= PW'(ring_size);
    end
  end

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    ring_empty |-> head_ptr == tail_ptr)
    else $error("empty ring with pointers apart");

  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    ring_empty |-> slot_present == '0)
    else $error("present slot in empty ring");

  a_clr_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |=> ring_empty && !started)
    else $error("reset command left ring or start mark");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !started |-> prefetch_count == '0)
    else $error("prefetch count before start");

endmodule

@@ src/adaptive_jitter_buffer_core.sv @@
// Order: a put runs decode, two put steps, adaptation if needed (plus a shrink if due),
//   then placement check and apply, repeated after each quarter eviction; a get runs decode,
//   a get step, adaptation if needed, the pop decision and a head read if it pops.
// Throughput: one item at a time; the next item is accepted in the cycle after the result
//   beat is loaded, while that beat may still wait for the receiver.
// Reset: synchronous, clears the ring, history and marks and loads register defaults;
//   present bits clear at once, no clearing pass.
module adaptive_jitter_buffer_core #(
  parameter int MAX_FRAMES   = ajb_pkg::MAX_FRAMES_DEF,
  parameter int PAYLOAD_BITS = ajb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ajb_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ajb_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ajb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ajb_pkg::LIMIT_W-1:0] cfg_data
);

  ajb_pkg::dp_cmd_t  cmd;
  ajb_pkg::dp_stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  ajb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ajb_datapath #(
    .MAX_FRAMES   (MAX_FRAMES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
